/* sv/srfpll_pkg.sv */
// Shared constants, types, the sine table and fixed-point helpers of the grid SRF PLL.
package srfpll_pkg;

    // Sizes of the fields and of the internal datapath.
    localparam int SMP_W       = 16;
    localparam int PH_W        = 32;
    localparam int SINE_DEPTH  = 1024;
    localparam int R_W         = $clog2(SINE_DEPTH);
    localparam int QUAD_BITS   = R_W + 2;
    localparam int ROM_AW      = $clog2(SINE_DEPTH + 1);
    localparam int SINE_W      = 17;
    localparam int WIDE_W      = 66;
    localparam int MUL_A_W     = 49;
    localparam int MUL_B_W     = 36;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int DIGIT_W     = 4;
    localparam int MUL_DIGITS  = MUL_B_W / DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
    localparam int DIV_N_W     = 47;
    localparam int DIV_CNT_W   = $clog2(DIV_N_W + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Fixed-point constants.
    localparam int INV_SQRT3   = 37837;
    localparam int DEADBAND    = 210;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LPF_COEF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOM_FREQ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_LIM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX   = 3'd7;

    // Status of a multi-cycle arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_DEPTH];

    localparam logic [63:0] POLY_C [0:5] = '{64'd1686629713, 64'd693598668, 64'd85569306,
                                              64'd5026995, 64'd172272, 64'd3864};

    // Quarter-wave sine in unsigned Q16, built from an integer odd polynomial.
    function automatic sine_rom_t build_sine();
        sine_rom_t   t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        for (int i = 0; i <= SINE_DEPTH; i++)
        begin
            x = (64'(i) << 30) / SINE_DEPTH;
            x2 = (x * x) >> 30;
            p = POLY_C[5];
            for (int k = 4; k >= 0; k--)
            begin
                p = POLY_C[k] - ((p * x2) >> 30);
            end
            p = (((p * x) >> 30) + 64'd8192) >> 14;
            t[i] = (p > 64'd65536) ? 17'd65536 : p[SINE_W-1:0];
        end
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

    // Shift right with rounding to nearest, halves away from zero.
    function automatic logic signed [WIDE_W-1:0] rnd_shift(input logic signed [WIDE_W-1:0] v,
                                                           input int unsigned s);
        logic [WIDE_W-1:0] mag;
        mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        mag = (mag + (WIDE_W'(1) << (s - 1))) >> s;
        return v[WIDE_W-1] ? -$signed(mag) : $signed(mag);
    endfunction

    // Saturate a wide signed value to a signed range of the given width.
    function automatic logic signed [WIDE_W-1:0] sat_to(input logic signed [WIDE_W-1:0] v,
                                                        input int unsigned bits);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = (WIDE_W'(1) <<< (bits - 1)) - WIDE_W'(1);
        lo = -hi - WIDE_W'(1);
        if (v > hi)
            return hi;
        else if (v < lo)
            return lo;
        return v;
    endfunction

endpackage

/* sv/srfpll_sine.sv */
// Quarter-wave sine table with a registered read port.
module srfpll_sine
    import srfpll_pkg::*;
(
    input  logic              clk,
    input  logic [ROM_AW-1:0] addr,
    output logic [SINE_W-1:0] data
);

    logic [SINE_W-1:0] data_reg;

    // Registered table read.
    always_ff @(posedge clk)
    begin
        data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

/* sv/srfpll_mul.sv */
// Digit-serial signed multiplier, one 4-bit digit of the second operand per cycle.
module srfpll_mul
    import srfpll_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [MUL_A_W-1:0]  op_a,
    input  logic signed [MUL_B_W-1:0]  op_b,
    output logic signed [MUL_P_W-1:0]  product,
    output unit_stat_t                 stat
);

    logic signed [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0]        b_reg;
    logic signed [MUL_P_W-1:0] p_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [DIGIT_W:0]   top_digit;
    logic signed [DIGIT_W:0]   low_digit;
    logic signed [MUL_P_W-1:0] first_term;
    logic signed [MUL_P_W-1:0] step_term;

    // The top digit carries the sign; the others are unsigned.
    assign top_digit  = (DIGIT_W+1)'($signed(op_b[MUL_B_W-1 -: DIGIT_W]));
    assign low_digit  = $signed({1'b0, b_reg[MUL_B_W-1 -: DIGIT_W]});
    assign first_term = op_a * top_digit;
    assign step_term  = a_reg * low_digit;

    // Horner accumulation from the most significant digit down.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= MUL_CNT_W'(MUL_DIGITS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand and partial product registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b << DIGIT_W;
            p_reg <= first_term;
        end
        else if (busy_reg)
        begin
            b_reg <= b_reg << DIGIT_W;
            p_reg <= (p_reg <<< DIGIT_W) + step_term;
        end
    end

    assign product   = p_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* sv/srfpll_div.sv */
// Bit-serial restoring divider for the integrator bound, one quotient bit per cycle.
module srfpll_div
    import srfpll_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        limit,
    input  logic [15:0]        gain,
    output logic [DIV_N_W-1:0] quotient,
    output unit_stat_t         stat
);

    logic [15:0]          rem_reg;
    logic [DIV_N_W-1:0]   num_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [16:0]          rem_sh;
    logic                 ge;
    logic [16:0]          rem_sub;

    // One trial subtraction per cycle; a zero divisor yields all ones.
    assign rem_sh  = {rem_reg, num_reg[DIV_N_W-1]};
    assign ge      = rem_sh >= {1'b0, gain};
    assign rem_sub = rem_sh - {1'b0, gain};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_N_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Remainder and dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= {limit, 31'd0};
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[15:0] : rem_sh[15:0];
            num_reg <= {num_reg[DIV_N_W-2:0], ge};
        end
    end

    assign quotient  = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* sv/grid_srf_pll.sv */
// Top level of the grid synchronous-reference-frame PLL with its sequencer.
//
// Channel   Direction  Content
// s_axis    in         tdata: phase_a_volts[15:0], phase_b_volts[31:16]
// m_axis    out        tdata: phase_angle, frequency, vq_smoothed, direct_volts, quad_volts
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// Each sample passes from an accepted transaction to the next ready state through
// ten digit-serial multiplications on the shared multiplier, plus two table reads,
// the clamp step, the output step, which waits for a free output register, and the idle state.
// The integrator bound divider runs in parallel and is never on the critical path.
// Reset clears the loop state and loads the default configuration; no clearing pass.
// A finished result waits in the output register while the next sample is accepted.
module grid_srf_pll
    import srfpll_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // phase_a_volts[15:0], phase_b_volts[31:16]
    input  logic [31:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // phase_angle[31:0], frequency[47:32], vq_smoothed[65:48], direct_volts[83:66],
    // quad_volts[101:84], zero fill[103:102]
    output logic [103:0]          m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_SIN   = 15'b000000000000010,
        ST_COS   = 15'b000000000000100,
        ST_BETA  = 15'b000000000001000,
        ST_VD1   = 15'b000000000010000,
        ST_VD2   = 15'b000000000100000,
        ST_VQ1   = 15'b000000001000000,
        ST_VQ2   = 15'b000000010000000,
        ST_LPF   = 15'b000000100000000,
        ST_INTEG = 15'b000001000000000,
        ST_PROP  = 15'b000010000000000,
        ST_GAIN  = 15'b000100000000000,
        ST_LIMIT = 15'b001000000000000,
        ST_INC   = 15'b010000000000000,
        ST_DONE  = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [15:0] lpf_coef_reg;
    logic [15:0] prop_gain_reg;
    logic [15:0] integ_gain_reg;
    logic [31:0] period_reg;
    logic [15:0] nom_freq_reg;
    logic [15:0] corr_lim_reg;
    logic [15:0] fmin_reg;
    logic [15:0] fmax_reg;

    // Loop state.
    logic [PH_W-1:0]    phase_reg;
    logic signed [23:0] filt_reg;
    logic signed [47:0] integ_reg;

    // Per-sample working registers.
    logic signed [SMP_W-1:0]  a_reg;
    logic signed [SMP_W-1:0]  b_reg;
    logic signed [17:0]       sn_reg;
    logic signed [17:0]       cs_reg;
    logic signed [16:0]       beta_reg;
    logic signed [WIDE_W-1:0] hold_reg;
    logic signed [17:0]       vd_reg;
    logic signed [17:0]       vq_reg;
    logic signed [23:0]       err_reg;
    logic signed [48:0]       integ_raw_reg;
    logic signed [16:0]       corr_reg;
    logic [15:0]              f_reg;
    logic                     issued_reg;

    // Output register.
    logic                     m_valid_reg;
    logic [31:0]              ph_out_reg;
    logic [15:0]              f_out_reg;
    logic [17:0]              vqs_out_reg;
    logic [17:0]              vd_out_reg;
    logic [17:0]              vq_out_reg;

    // Arithmetic units.
    logic                      mul_start;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    unit_stat_t                mul_stat;
    logic [DIV_N_W-1:0]        bound;
    unit_stat_t                div_stat;
    logic [SINE_W-1:0]         rom_data;
    logic [ROM_AW-1:0]         rom_addr;

    logic                      in_fire;
    logic                      mul_state;
    logic                      out_free;

    // Table position of the current phase and its quadrant decode.
    logic [PH_W-8+QUAD_BITS-1:0] pos_tmp;
    logic [QUAD_BITS-1:0]        pos;
    logic [1:0]                  q_sin;
    logic [1:0]                  q_cos;
    logic [R_W-1:0]              r_idx;
    logic [ROM_AW-1:0]           sin_addr;
    logic [ROM_AW-1:0]           cos_addr;
    logic signed [17:0]          rom_signed;

    // Step results.
    logic signed [WIDE_W-1:0]   p66;
    logic signed [WIDE_W-1:0]   filt_wide;
    logic signed [23:0]         filt_new;
    logic signed [24:0]         lpf_diff;
    logic signed [WIDE_W-1:0]   corr_wide;
    logic signed [WIDE_W-1:0]   lim_wide;
    logic signed [48:0]         bound_s;
    logic signed [17:0]         f_sum;
    logic [47:0]                inc_prod;
    logic [40:0]                inc;
    logic signed [WIDE_W-1:0]   vqs_wide;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign pos_tmp  = {phase_reg[PH_W-1:8], {QUAD_BITS{1'b0}}}
                      + (PH_W-8+QUAD_BITS)'(1 << (PH_W - 9));
    assign pos      = pos_tmp[PH_W-8 +: QUAD_BITS];
    assign q_sin    = pos[QUAD_BITS-1 -: 2];
    assign q_cos    = q_sin + 2'd1;
    assign r_idx    = pos[R_W-1:0];
    assign sin_addr = q_sin[0] ? ROM_AW'(SINE_DEPTH) - ROM_AW'(r_idx) : ROM_AW'(r_idx);
    assign cos_addr = q_cos[0] ? ROM_AW'(SINE_DEPTH) - ROM_AW'(r_idx) : ROM_AW'(r_idx);
    assign rom_addr = (state_reg == ST_COS) ? cos_addr : sin_addr;
    assign rom_signed = $signed({1'b0, rom_data});

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_BETA:
            begin
                mul_a = MUL_A_W'(a_reg) + (MUL_A_W'(b_reg) <<< 1);
                mul_b = MUL_B_W'(INV_SQRT3);
            end
            ST_VD1:
            begin
                mul_a = MUL_A_W'(a_reg);
                mul_b = MUL_B_W'(cs_reg);
            end
            ST_VD2:
            begin
                mul_a = MUL_A_W'(beta_reg);
                mul_b = MUL_B_W'(sn_reg);
            end
            ST_VQ1:
            begin
                mul_a = MUL_A_W'(beta_reg);
                mul_b = MUL_B_W'(cs_reg);
            end
            ST_VQ2:
            begin
                mul_a = MUL_A_W'(a_reg);
                mul_b = MUL_B_W'(sn_reg);
            end
            ST_LPF:
            begin
                mul_a = MUL_A_W'(lpf_diff);
                mul_b = MUL_B_W'(lpf_coef_reg);
            end
            ST_INTEG:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(period_reg);
            end
            ST_PROP:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(prop_gain_reg);
            end
            ST_GAIN:
            begin
                mul_a = integ_raw_reg;
                mul_b = MUL_B_W'(integ_gain_reg);
            end
            ST_INC:
            begin
                mul_a = MUL_A_W'(f_reg);
                mul_b = MUL_B_W'(period_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_state = (state_reg == ST_BETA) || (state_reg == ST_VD1) ||
                       (state_reg == ST_VD2) || (state_reg == ST_VQ1) ||
                       (state_reg == ST_VQ2) || (state_reg == ST_LPF) ||
                       (state_reg == ST_INTEG) || (state_reg == ST_PROP) ||
                       (state_reg == ST_GAIN) || (state_reg == ST_INC);
    assign mul_start = mul_state && !issued_reg && !mul_stat.busy;

    // Fixed-point step arithmetic on the multiplier result.
    assign p66       = mul_p[WIDE_W-1:0];
    assign lpf_diff  = (25'(vq_reg) <<< 6) - 25'(filt_reg);
    assign filt_wide = sat_to(WIDE_W'(filt_reg) + rnd_shift(p66, 16), 24);
    assign filt_new  = filt_wide[23:0];
    assign lim_wide  = WIDE_W'(corr_lim_reg);
    assign corr_wide = rnd_shift(hold_reg + p66, 31);
    assign bound_s   = $signed({2'b00, bound});
    assign f_sum     = 18'(nom_freq_reg) + 18'(corr_reg);
    assign inc_prod  = mul_p[47:0];
    assign inc       = 41'((inc_prod + 48'd128) >> 8);
    assign vqs_wide  = sat_to(rnd_shift(WIDE_W'(filt_reg), 6), 18);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_SIN;
            ST_SIN:   state_next = ST_COS;
            ST_COS:   state_next = ST_BETA;
            ST_BETA:  if (mul_stat.done && issued_reg) state_next = ST_VD1;
            ST_VD1:   if (mul_stat.done && issued_reg) state_next = ST_VD2;
            ST_VD2:   if (mul_stat.done && issued_reg) state_next = ST_VQ1;
            ST_VQ1:   if (mul_stat.done && issued_reg) state_next = ST_VQ2;
            ST_VQ2:   if (mul_stat.done && issued_reg) state_next = ST_LPF;
            ST_LPF:   if (mul_stat.done && issued_reg) state_next = ST_INTEG;
            ST_INTEG: if (mul_stat.done && issued_reg) state_next = ST_PROP;
            ST_PROP:  if (mul_stat.done && issued_reg) state_next = ST_GAIN;
            ST_GAIN:  if (mul_stat.done && issued_reg) state_next = ST_LIMIT;
            ST_LIMIT: if (div_stat.done) state_next = ST_INC;
            ST_INC:   if (mul_stat.done && issued_reg) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control registers, configuration and loop state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issued_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            lpf_coef_reg   <= 16'd328;
            prop_gain_reg  <= 16'd256;
            integ_gain_reg <= 16'd256;
            period_reg     <= 32'd429497;
            nom_freq_reg   <= 16'd12800;
            corr_lim_reg   <= 16'd1280;
            fmin_reg       <= 16'd11520;
            fmax_reg       <= 16'd14080;
            phase_reg      <= '0;
            filt_reg       <= '0;
            integ_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (mul_start)
                issued_reg <= 1'b1;
            else if (mul_stat.done)
                issued_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LPF_COEF:   lpf_coef_reg   <= cfg_data[15:0];
                    REG_PROP_GAIN:  prop_gain_reg  <= cfg_data[15:0];
                    REG_INTEG_GAIN: integ_gain_reg <= cfg_data[15:0];
                    REG_PERIOD:     period_reg     <= cfg_data;
                    REG_NOM_FREQ:   nom_freq_reg   <= cfg_data[15:0];
                    REG_CORR_LIM:   corr_lim_reg   <= cfg_data[15:0];
                    REG_FREQ_MIN:   fmin_reg       <= cfg_data[15:0];
                    REG_FREQ_MAX:   fmax_reg       <= cfg_data[15:0];
                    default:        lpf_coef_reg   <= lpf_coef_reg;
                endcase
            end

            if (state_reg == ST_LPF && mul_stat.done && issued_reg)
                filt_reg <= filt_new;

            if (state_reg == ST_LIMIT && div_stat.done)
            begin
                if (integ_raw_reg > bound_s)
                    integ_reg <= 48'(bound_s);
                else if (integ_raw_reg < -bound_s)
                    integ_reg <= 48'(-bound_s);
                else
                    integ_reg <= 48'(integ_raw_reg);
            end

            if (state_reg == ST_INC && mul_stat.done && issued_reg)
                phase_reg <= phase_reg + inc[PH_W-1:0];

            if (state_reg == ST_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Datapath working registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_reg <= $signed(s_axis_tdata[15:0]);
            b_reg <= $signed(s_axis_tdata[31:16]);
        end

        if (state_reg == ST_COS)
            sn_reg <= q_sin[1] ? -rom_signed : rom_signed;
        if (state_reg == ST_BETA && !issued_reg)
            cs_reg <= q_cos[1] ? -rom_signed : rom_signed;

        if (mul_stat.done && issued_reg)
        begin
            case (state_reg)
                ST_BETA:  beta_reg <= 17'(rnd_shift(p66, 16));
                ST_VD1:   hold_reg <= p66;
                ST_VD2:   vd_reg   <= 18'(sat_to(rnd_shift(hold_reg + p66, 16), 18));
                ST_VQ1:   hold_reg <= p66;
                ST_VQ2:   vq_reg   <= 18'(sat_to(rnd_shift(hold_reg - p66, 16), 18));
                ST_LPF:
                begin
                    if (filt_new > -24'sd210 && filt_new < 24'sd210)
                        err_reg <= '0;
                    else
                        err_reg <= filt_new;
                end
                ST_INTEG: integ_raw_reg <= 49'(integ_reg) + 49'(rnd_shift(p66, 22));
                ST_PROP:  hold_reg <= p66 <<< 10;
                ST_GAIN:
                begin
                    if (corr_wide > lim_wide)
                        corr_reg <= 17'(lim_wide);
                    else if (corr_wide < -lim_wide)
                        corr_reg <= 17'(-lim_wide);
                    else
                        corr_reg <= 17'(corr_wide);
                end
                default:  hold_reg <= hold_reg;
            endcase
        end

        if (state_reg == ST_LIMIT)
        begin
            if (f_sum > $signed({2'b00, fmax_reg}))
                f_reg <= fmax_reg;
            else if (f_sum < $signed({2'b00, fmin_reg}))
                f_reg <= fmin_reg;
            else
                f_reg <= f_sum[15:0];
        end

        if (state_reg == ST_DONE && out_free)
        begin
            ph_out_reg  <= phase_reg;
            f_out_reg   <= f_reg;
            vqs_out_reg <= vqs_wide[17:0];
            vd_out_reg  <= vd_reg;
            vq_out_reg  <= vq_reg;
        end
    end

    srfpll_sine u_sine (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    srfpll_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p),
        .stat    (mul_stat)
    );

    srfpll_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .limit    (corr_lim_reg),
        .gain     (integ_gain_reg),
        .quotient (bound),
        .stat     (div_stat)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, vq_out_reg, vd_out_reg, vqs_out_reg, f_out_reg, ph_out_reg};

    // The clamped integrator value lies within the bound.
    a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIMIT && div_stat.done) |=>
            (49'(integ_reg) <= bound_s && 49'(integ_reg) >= -bound_s))
        else $error("integrator outside its bound after clamp");

    // A delivered frequency respects ordered clamp limits.
    a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && fmin_reg <= fmax_reg) |->
            (f_out_reg >= fmin_reg && f_out_reg <= fmax_reg))
        else $error("frequency outside clamp range");

    // The shared multiplier is idle whenever a new sample may enter.
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!mul_stat.busy && !issued_reg))
        else $error("multiplier busy while sequencer idle");

endmodule
